// File: rtl/core/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int OPCODE_W  = 3;
  localparam int INDEX_W   = 10;
  localparam int STATUS_W  = 2;
  localparam int LEN_CFG_W = 11;

  localparam logic [LEN_CFG_W-1:0] LEN_CFG_RESET = 11'd1024;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INIT  = 3'd0,
    OP_ALLOC = 3'd1,
    OP_FREE  = 3'd2,
    OP_SET   = 3'd3,
    OP_QUERY = 3'd4
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_CLEAR = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

endpackage

// File: rtl/core/bba_if.sv
// ----------------------------------------------------------------------------
// bba_if
// Request, response and configuration channels of the bitmap block allocator.
// ----------------------------------------------------------------------------
interface bba_req_if;
  logic                          valid;
  logic                          ready;
  logic [bba_pkg::OPCODE_W-1:0]  opcode;
  logic [bba_pkg::INDEX_W-1:0]   item_index;
  logic                          bit_value;

  modport source (output valid, opcode, item_index, bit_value, input ready);
  modport sink   (input valid, opcode, item_index, bit_value, output ready);
endinterface

interface bba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bba_pkg::INDEX_W-1:0]   result_index;
  logic [bba_pkg::STATUS_W-1:0]  status;
  logic                          bit_state;

  modport source (output valid, result_index, status, bit_state, input ready);
  modport sink   (input valid, result_index, status, bit_state, output ready);
endinterface

interface bba_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bba_pkg::LEN_CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: rtl/core/bba_ffz.sv
// ----------------------------------------------------------------------------
// bba_ffz
// Finds the lowest clear bit of a vector.
// ----------------------------------------------------------------------------
module bba_ffz #(
  parameter int W = 64
) (
  input  logic [W-1:0]                    vec,
  output logic [((W > 1) ? $clog2(W) : 1)-1:0] pos,
  output logic                            found
);
  localparam int PW = (W > 1) ? $clog2(W) : 1;

  always_comb begin
    pos   = '0;
    found = 1'b0;
    for (int i = W - 1; i >= 0; i--) begin
      if (!vec[i]) begin
        pos   = PW'(i);
        found = 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit bit allocator over a bitmap held in a word memory, with a
// per-word full summary that picks the word for an allocation.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  req      in   valid/ready   opcode, item_index, bit_value
//  rsp      out  valid/ready   result_index, status, bit_state
//  cfg      in   valid/ready   data (bits_in_use)
//
// Per request, the accepting edge reads one word of the bitmap memory and
// the execute state modifies it, writes it back and loads the response
// register, as the memory has a single read port. Reset clears the per-word
// valid and full flags, so no clearing pass runs. A new request is accepted
// while a response waits; it stalls in its write back cycle until the
// response register is free. WORD_BITS must be a power of 2 (not checked).
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
  parameter int MAX_BITS  = 1024,
  parameter int WORD_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  bba_req_if.sink     req,
  bba_rsp_if.source   rsp,
  bba_cfg_if.sink     cfg
);
  import bba_pkg::*;

  localparam int NWORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WBL    = $clog2(WORD_BITS);
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int LEN_W  = $clog2(MAX_BITS + 1);
  localparam int CW     = (LEN_W > LEN_CFG_W) ? LEN_W : LEN_CFG_W;

  state_t                 state, state_next;
  logic [LEN_CFG_W-1:0]   len_cfg;
  logic [LEN_W-1:0]       active;
  logic [NWORDS-1:0]      word_valid;
  logic [NWORDS-1:0]      word_full;

  logic [WORD_BITS-1:0]   mem [NWORDS];
  logic [WORD_BITS-1:0]   rdata;

  logic [OPCODE_W-1:0]    op;
  logic [INDEX_W-1:0]     idx;
  logic                   val;
  logic [AW-1:0]          addr;
  logic                   alloc_none;
  logic [LEN_W-1:0]       init_len;

  logic                   out_valid;
  logic [INDEX_W-1:0]     out_index;
  status_t                out_status;
  logic                   out_bit;

  logic                   req_fire;
  logic                   exec_done;
  logic [AW-1:0]          free_word;
  logic                   free_found;
  logic [CW-1:0]          free_base;
  logic                   alloc_avail;
  logic [CW-1:0]          req_word_ext;
  logic [AW-1:0]          rd_addr;
  logic [LEN_W-1:0]       len_sat;

  logic [WORD_BITS-1:0]   cur_word;
  logic [WBL-1:0]         bit_pos;
  logic [WORD_BITS-1:0]   bit_mask;
  logic                   in_range;
  logic [WBL-1:0]         zero_pos;
  logic                   zero_found;
  logic [CW-1:0]          grant_ext;
  logic                   grant_ok;
  logic [LEN_W-1:0]       init_last_ext;
  logic [WBL-1:0]         init_rem;
  logic [WORD_BITS-1:0]   init_mask;

  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [WORD_BITS-1:0]   wr_data;
  logic [INDEX_W-1:0]     res_index;
  status_t                res_status;
  logic                   res_bit;

  bba_ffz #(.W(NWORDS)) u_word_scan (
    .vec   (word_full),
    .pos   (free_word),
    .found (free_found)
  );

  bba_ffz #(.W(WORD_BITS)) u_bit_scan (
    .vec   (cur_word),
    .pos   (zero_pos),
    .found (zero_found)
  );

  // Request side: choose the word to read.
  assign req_fire     = req.valid && req.ready;
  assign free_base    = CW'(free_word) << WBL;
  assign alloc_avail  = free_found && (free_base < CW'(active));
  assign req_word_ext = CW'(req.item_index) >> WBL;
  assign rd_addr      = (req.opcode == OP_ALLOC) ? free_word : req_word_ext[AW-1:0];
  assign len_sat      = (CW'(len_cfg) > CW'(MAX_BITS)) ? LEN_W'(MAX_BITS) : LEN_W'(len_cfg);

  // Execute side.
  assign exec_done     = (state == S_EXEC) && (!out_valid || rsp.ready);
  assign cur_word      = word_valid[addr] ? rdata : '0;
  assign bit_pos       = idx[WBL-1:0];
  assign bit_mask      = WORD_BITS'(1) << bit_pos;
  assign in_range      = CW'(idx) < CW'(active);
  assign grant_ext     = (CW'(addr) << WBL) + CW'(zero_pos);
  assign grant_ok      = !alloc_none && zero_found && (grant_ext < CW'(active));
  assign init_last_ext = (init_len - LEN_W'(1)) >> WBL;
  assign init_rem      = init_len[WBL-1:0];
  assign init_mask     = ~((WORD_BITS'(1) << init_rem) - WORD_BITS'(1));

  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = addr;
    wr_data    = cur_word;
    res_index  = '0;
    res_status = ST_OK;
    res_bit    = 1'b0;
    unique case (op)
      OP_INIT: begin
        if (init_len != '0 && init_rem != '0) begin
          wr_en   = 1'b1;
          wr_addr = init_last_ext[AW-1:0];
          wr_data = init_mask;
        end
      end
      OP_ALLOC: begin
        if (grant_ok) begin
          wr_en     = 1'b1;
          wr_data   = cur_word | (WORD_BITS'(1) << zero_pos);
          res_index = grant_ext[INDEX_W-1:0];
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_FREE: begin
        if (!in_range) begin
          res_status = ST_RANGE;
        end else if ((cur_word & bit_mask) == '0) begin
          res_status = ST_CLEAR;
        end else begin
          wr_en   = 1'b1;
          wr_data = cur_word & ~bit_mask;
        end
      end
      OP_SET: begin
        if (!in_range) begin
          res_status = ST_RANGE;
        end else begin
          wr_en   = 1'b1;
          wr_data = val ? (cur_word | bit_mask) : (cur_word & ~bit_mask);
        end
      end
      OP_QUERY: begin
        if (!in_range) begin
          res_status = ST_RANGE;
        end else begin
          res_bit = |(cur_word & bit_mask);
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    cfg.ready = 1'b1;
    unique case (state)
      S_IDLE:  req.ready = 1'b1;
      S_EXEC:  req.ready = 1'b0;
      default: req.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      len_cfg    <= LEN_CFG_RESET;
      active     <= LEN_W'(MAX_BITS);
      word_valid <= '0;
      word_full  <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        len_cfg <= cfg.data;
      end
      if (exec_done) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (exec_done) begin
        if (op == OP_INIT) begin
          active     <= init_len;
          word_full  <= '0;
          word_valid <= wr_en ? (NWORDS'(1) << wr_addr) : '0;
        end else if (wr_en) begin
          word_valid[wr_addr] <= 1'b1;
          word_full[wr_addr]  <= &wr_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      op         <= req.opcode;
      idx        <= req.item_index;
      val        <= req.bit_value;
      addr       <= rd_addr;
      alloc_none <= !alloc_avail;
      init_len   <= len_sat;
    end
    if (exec_done) begin
      out_index  <= res_index;
      out_status <= res_status;
      out_bit    <= res_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_done && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (req_fire) begin
      rdata <= mem[rd_addr];
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.result_index = out_index;
  assign rsp.status       = out_status;
  assign rsp.bit_state    = out_bit;

`ifndef SYNTH
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state == S_EXEC)
    else $error("accepted request did not enter execute");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC && !exec_done |=> state == S_EXEC && $stable(op) && $stable(addr))
    else $error("stalled request lost its state");

  a_full_index: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_FULL |-> rsp.result_index == '0)
    else $error("full response carries an index");

  a_bit_status: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.bit_state |-> rsp.status == ST_OK)
    else $error("bit state reported on a failed request");
`endif

endmodule
